// File: rtl/assert_macros.svh
// Assertion macros for the dirty-rectangle RTL.
// Bodies compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/dra_pkg.sv
// Shared constants, codes and types for the dirty-rectangle accumulator.
// No dependencies.
`default_nettype none
package dra_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int RECT_W         = 16;
  localparam int REQ_W          = 2;
  localparam int PCT_W          = 8;
  localparam int AREA_OUT_W     = 24;
  localparam int CFG_IDX_W      = 2;

  localparam int unsigned PCT_SCALE    = 100;
  localparam int unsigned SCREEN_W_RST = 128;
  localparam int unsigned SCREEN_H_RST = 64;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_PCT = 2'd2;

  typedef struct packed {
    logic went_full;
    logic add_dropped;
  } flags_t;

endpackage
`default_nettype wire

// File: rtl/dra_in_if.sv
// Request channel: valid/ready plus one add/clear/mark-full request word.
// Depends on dra_pkg.
`default_nettype none
interface dra_in_if;
  import dra_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [RECT_W-1:0] rect_x;
  logic signed [RECT_W-1:0] rect_y;
  logic signed [RECT_W-1:0] rect_w;
  logic signed [RECT_W-1:0] rect_h;

  modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink   (input valid, req_type, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface
`default_nettype wire

// File: rtl/dra_out_if.sv
// Result channel: valid/ready plus the dirty box, its area and status flags.
// Depends on dra_pkg.
`default_nettype none
interface dra_out_if #(
  parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
);
  import dra_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   dirty_valid;
  logic [COORD_BITS-1:0]  dirty_left;
  logic [COORD_BITS-1:0]  dirty_top;
  logic [COORD_BITS-1:0]  dirty_right;
  logic [COORD_BITS-1:0]  dirty_bottom;
  logic [AREA_OUT_W-1:0]  dirty_area;
  logic                   went_full;
  logic                   add_dropped;

  modport source (output valid, dirty_valid, dirty_left, dirty_top, dirty_right,
                  dirty_bottom, dirty_area, went_full, add_dropped, input ready);
  modport sink   (input valid, dirty_valid, dirty_left, dirty_top, dirty_right,
                  dirty_bottom, dirty_area, went_full, add_dropped, output ready);
endinterface
`default_nettype wire

// File: rtl/dra_core.sv
// Next-state logic: clip a request to the screen, merge it into the box,
// check the full-screen promotion and pick the new region. Depends on dra_pkg.
`default_nettype none
module dra_core #(
  parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
  input  logic [dra_pkg::REQ_W-1:0]         req_type,
  input  logic signed [dra_pkg::RECT_W-1:0] rect_x,
  input  logic signed [dra_pkg::RECT_W-1:0] rect_y,
  input  logic signed [dra_pkg::RECT_W-1:0] rect_w,
  input  logic signed [dra_pkg::RECT_W-1:0] rect_h,
  input  logic [COORD_BITS-1:0]             screen_w,
  input  logic [COORD_BITS-1:0]             screen_h,
  input  logic [dra_pkg::PCT_W-1:0]         full_pct,
  input  logic [2*COORD_BITS-1:0]           screen_area,
  input  logic                              cur_valid,
  input  logic [COORD_BITS-1:0]             cur_left,
  input  logic [COORD_BITS-1:0]             cur_top,
  input  logic [COORD_BITS-1:0]             cur_right,
  input  logic [COORD_BITS-1:0]             cur_bottom,
  input  logic [2*COORD_BITS-1:0]           cur_area,
  output logic                              nxt_valid,
  output logic [COORD_BITS-1:0]             nxt_left,
  output logic [COORD_BITS-1:0]             nxt_top,
  output logic [COORD_BITS-1:0]             nxt_right,
  output logic [COORD_BITS-1:0]             nxt_bottom,
  output logic [2*COORD_BITS-1:0]           nxt_area,
  output dra_pkg::flags_t                   nxt_flags
);
  import dra_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int ATW = 2*CB + 9;   // holds area*100 and screen_area*pct

  logic signed [RECT_W-1:0] far_x, far_y, near_x, near_y;
  logic signed [RECT_W-1:0] lim_x, lim_y, clip_x, clip_y;
  logic                     screen_ok, size_ok, keep, promote;
  logic [CB-1:0]            new_l, new_t, new_r, new_b;
  logic [CB-1:0]            mrg_l, mrg_t, mrg_r, mrg_b;
  logic [CB:0]              span_x, span_y;
  logic [2*CB+1:0]          mrg_area;
  logic [ATW-1:0]           area_pct, thresh;
  logic [CB-1:0]            full_r, full_b;

  assign screen_ok = (screen_w != '0) && (screen_h != '0);
  assign size_ok   = !rect_w[RECT_W-1] && (rect_w != '0) &&
                     !rect_h[RECT_W-1] && (rect_h != '0);

  // far edges wrap at 16 bits
  assign far_x  = rect_x + rect_w - 16'sd1;
  assign far_y  = rect_y + rect_h - 16'sd1;
  assign near_x = rect_x[RECT_W-1] ? '0 : rect_x;
  assign near_y = rect_y[RECT_W-1] ? '0 : rect_y;

  assign full_r = screen_w - CB'(1);
  assign full_b = screen_h - CB'(1);
  assign lim_x  = $signed({{(RECT_W-CB){1'b0}}, full_r});
  assign lim_y  = $signed({{(RECT_W-CB){1'b0}}, full_b});
  assign clip_x = (far_x > lim_x) ? lim_x : far_x;
  assign clip_y = (far_y > lim_y) ? lim_y : far_y;

  assign keep = screen_ok && size_ok && !(clip_x < near_x) && !(clip_y < near_y);

  assign new_l = near_x[CB-1:0];
  assign new_t = near_y[CB-1:0];
  assign new_r = clip_x[CB-1:0];
  assign new_b = clip_y[CB-1:0];

  assign mrg_l = (!cur_valid || new_l < cur_left)   ? new_l : cur_left;
  assign mrg_t = (!cur_valid || new_t < cur_top)    ? new_t : cur_top;
  assign mrg_r = (!cur_valid || new_r > cur_right)  ? new_r : cur_right;
  assign mrg_b = (!cur_valid || new_b > cur_bottom) ? new_b : cur_bottom;

  assign span_x   = {1'b0, mrg_r} - {1'b0, mrg_l} + (CB+1)'(1);
  assign span_y   = {1'b0, mrg_b} - {1'b0, mrg_t} + (CB+1)'(1);
  assign mrg_area = span_x * span_y;

  assign area_pct = ATW'(mrg_area) * ATW'(PCT_SCALE);
  assign thresh   = ATW'(screen_area) * ATW'(full_pct);
  assign promote  = keep && (full_pct != '0) && (area_pct >= thresh);

  always_comb begin
    nxt_valid  = cur_valid;
    nxt_left   = cur_left;
    nxt_top    = cur_top;
    nxt_right  = cur_right;
    nxt_bottom = cur_bottom;
    nxt_area   = cur_area;
    nxt_flags  = '0;
    unique case (req_type)
      REQ_ADD: begin
        nxt_flags.add_dropped = !keep;
        nxt_flags.went_full   = promote;
        if (promote) begin
          nxt_valid  = 1'b1;
          nxt_left   = '0;
          nxt_top    = '0;
          nxt_right  = full_r;
          nxt_bottom = full_b;
          nxt_area   = screen_area;
        end else if (keep) begin
          nxt_valid  = 1'b1;
          nxt_left   = mrg_l;
          nxt_top    = mrg_t;
          nxt_right  = mrg_r;
          nxt_bottom = mrg_b;
          nxt_area   = mrg_area[2*CB-1:0];
        end
      end
      REQ_CLEAR: begin
        nxt_valid  = 1'b0;
        nxt_left   = '0;
        nxt_top    = '0;
        nxt_right  = '0;
        nxt_bottom = '0;
        nxt_area   = '0;
      end
      REQ_FULL: begin
        if (screen_ok) begin
          nxt_valid  = 1'b1;
          nxt_left   = '0;
          nxt_top    = '0;
          nxt_right  = full_r;
          nxt_bottom = full_b;
          nxt_area   = screen_area;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/dirty_rect_accumulator_top.sv
// Dirty-rectangle accumulator: one bounding box of pixels to redraw.
// A request accepted into the input register reaches the result register when the
// output is free; one request per cycle unless out_ch.ready stalls. The box update,
// area multiply and promotion compare all close in the single stage in between.
// Reset (synchronous, rst_n low): box cleared, screen 128x64, promotion off.
`default_nettype none
`include "assert_macros.svh"
module dirty_rect_accumulator_top #(
  parameter int COORD_BITS = dra_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dra_in_if.sink                              in_ch,
  dra_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [dra_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [((COORD_BITS > dra_pkg::PCT_W) ? COORD_BITS : dra_pkg::PCT_W)-1:0] cfg_data
);
  import dra_pkg::*;

  localparam int CB = COORD_BITS;
  localparam logic [CB-1:0]   SW_RST   = CB'(SCREEN_W_RST);
  localparam logic [CB-1:0]   SH_RST   = CB'(SCREEN_H_RST);
  localparam logic [2*CB-1:0] PROD_RST = (2*CB)'(SW_RST) * (2*CB)'(SH_RST);

  // configuration
  logic [CB-1:0]    screen_w_r, screen_w_nxt;
  logic [CB-1:0]    screen_h_r, screen_h_nxt;
  logic [PCT_W-1:0] full_pct_r, full_pct_nxt;
  logic [2*CB-1:0]  screen_area_r, screen_area_nxt;

  // input register
  logic                     s1_valid_r;
  logic [REQ_W-1:0]         s1_req_r;
  logic signed [RECT_W-1:0] s1_x_r, s1_y_r, s1_w_r, s1_h_r;

  // region state, also the result payload
  logic            region_valid_r, region_valid_nxt;
  logic [CB-1:0]   region_left_r, region_left_nxt;
  logic [CB-1:0]   region_top_r, region_top_nxt;
  logic [CB-1:0]   region_right_r, region_right_nxt;
  logic [CB-1:0]   region_bottom_r, region_bottom_nxt;
  logic [2*CB-1:0] region_area_r, region_area_nxt;
  flags_t          flags_r, flags_nxt;
  logic            out_valid_r;

  logic in_acc, out_free, s1_adv;
  logic [2*CB+AREA_OUT_W-1:0] area_ext;

  always_comb begin
    screen_w_nxt = screen_w_r;
    screen_h_nxt = screen_h_r;
    full_pct_nxt = full_pct_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SCREEN_W: screen_w_nxt = cfg_data[CB-1:0];
        CFG_SCREEN_H: screen_h_nxt = cfg_data[CB-1:0];
        CFG_FULL_PCT: full_pct_nxt = cfg_data[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // only one dimension changes per write, so this is one multiply
  assign screen_area_nxt = (2*CB)'(screen_w_nxt) * (2*CB)'(screen_h_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r    <= SW_RST;
      screen_h_r    <= SH_RST;
      full_pct_r    <= '0;
      screen_area_r <= PROD_RST;
    end else begin
      screen_w_r    <= screen_w_nxt;
      screen_h_r    <= screen_h_nxt;
      full_pct_r    <= full_pct_nxt;
      screen_area_r <= screen_area_nxt;
    end
  end

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_ch.req_type;
      s1_x_r   <= in_ch.rect_x;
      s1_y_r   <= in_ch.rect_y;
      s1_w_r   <= in_ch.rect_w;
      s1_h_r   <= in_ch.rect_h;
    end
  end

  dra_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .req_type    (s1_req_r),
    .rect_x      (s1_x_r),
    .rect_y      (s1_y_r),
    .rect_w      (s1_w_r),
    .rect_h      (s1_h_r),
    .screen_w    (screen_w_r),
    .screen_h    (screen_h_r),
    .full_pct    (full_pct_r),
    .screen_area (screen_area_r),
    .cur_valid   (region_valid_r),
    .cur_left    (region_left_r),
    .cur_top     (region_top_r),
    .cur_right   (region_right_r),
    .cur_bottom  (region_bottom_r),
    .cur_area    (region_area_r),
    .nxt_valid   (region_valid_nxt),
    .nxt_left    (region_left_nxt),
    .nxt_top     (region_top_nxt),
    .nxt_right   (region_right_nxt),
    .nxt_bottom  (region_bottom_nxt),
    .nxt_area    (region_area_nxt),
    .nxt_flags   (flags_nxt)
  );

  // region only moves when a result is loaded, so it doubles as the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_valid_r  <= 1'b0;
      region_left_r   <= '0;
      region_top_r    <= '0;
      region_right_r  <= '0;
      region_bottom_r <= '0;
      region_area_r   <= '0;
      flags_r         <= '0;
    end else if (s1_adv) begin
      region_valid_r  <= region_valid_nxt;
      region_left_r   <= region_left_nxt;
      region_top_r    <= region_top_nxt;
      region_right_r  <= region_right_nxt;
      region_bottom_r <= region_bottom_nxt;
      region_area_r   <= region_area_nxt;
      flags_r         <= flags_nxt;
    end
  end

  assign area_ext = {{AREA_OUT_W{1'b0}}, region_area_r};

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dirty_valid  = region_valid_r;
  assign out_ch.dirty_left   = region_left_r;
  assign out_ch.dirty_top    = region_top_r;
  assign out_ch.dirty_right  = region_right_r;
  assign out_ch.dirty_bottom = region_bottom_r;
  assign out_ch.dirty_area   = area_ext[AREA_OUT_W-1:0];
  assign out_ch.went_full    = flags_r.went_full;
  assign out_ch.add_dropped  = flags_r.add_dropped;

  `AST_IMP(a_flags_excl, clk, rst_n, out_valid_r, !(flags_r.went_full && flags_r.add_dropped), "went_full and add_dropped both set")
  `AST_IMP(a_empty_zero, clk, rst_n, !region_valid_r, (region_left_r == '0) && (region_top_r == '0) && (region_right_r == '0) && (region_bottom_r == '0) && (region_area_r == '0), "empty region not all zero")
  `AST_IMP(a_box_order, clk, rst_n, region_valid_r, (region_left_r <= region_right_r) && (region_top_r <= region_bottom_r), "region edges out of order")
  `AST_NXT(a_clear_empties, clk, rst_n, s1_adv && (s1_req_r == REQ_CLEAR), !region_valid_r && !flags_r.went_full && !flags_r.add_dropped, "clear left region held")
  `AST_IMP(a_full_origin, clk, rst_n, out_valid_r && flags_r.went_full, region_valid_r && (region_left_r == '0) && (region_top_r == '0), "promotion did not cover the screen origin")

endmodule
`default_nettype wire
